// ----- hw/rtl/smce_pkg.sv -----
package smce_pkg;

    localparam int SMCE_COLUMNS     = 256;
    localparam int SMCE_OFF_W       = 12;
    localparam int SMCE_HEIGHT_W    = 11;
    localparam int SMCE_ROW_W       = 10;
    localparam int SMCE_TICK_W      = 6;
    localparam int SMCE_CFG_IDX_W   = 1;
    localparam int SMCE_CFG_DATA_W  = 11;

    localparam logic [SMCE_HEIGHT_W-1:0] SMCE_HEIGHT_RST = 11'd200;

    // item function codes
    localparam logic [1:0] FUNC_INIT  = 2'd0;
    localparam logic [1:0] FUNC_TICK  = 2'd1;
    localparam logic [1:0] FUNC_QUERY = 2'd2;

    // configuration register indexes
    localparam logic [SMCE_CFG_IDX_W-1:0] CFG_HEIGHT = 1'd0;
    localparam logic [SMCE_CFG_IDX_W-1:0] CFG_HIRES  = 1'd1;

    typedef struct packed {
        logic [1:0]             func;
        logic [7:0]             column;
        logic [7:0]             random_byte;
        logic [SMCE_TICK_W-1:0] tick_count;
        logic [SMCE_ROW_W-1:0]  row;
    } t_item;

    typedef struct packed {
        logic signed [SMCE_OFF_W-1:0] offset;
        logic                         column_busy;
        logic                         from_end;
        logic [SMCE_ROW_W-1:0]        source_row;
    } t_result;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic index;
        logic read;
        logic load;
        logic step;
        logic finish;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic is_tick;
        logic ticks_zero;
    } t_dp_stat;

endpackage

// ----- hw/rtl/smce_ctrl.sv -----
module smce_ctrl
    import smce_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_INDEX,
        S_READ,
        S_LOAD,
        S_TICK,
        S_FINISH
    } t_state;

    t_state r_state;
    logic   r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_state <= S_INDEX;
                        r_busy  <= 1'b1;
                    end
                end
                S_INDEX:  r_state <= S_READ;
                S_READ:   r_state <= S_LOAD;
                S_LOAD:   r_state <= i_stat.is_tick ? S_TICK : S_FINISH;
                S_TICK: begin
                    if (i_stat.ticks_zero) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.capture = (r_state == S_IDLE) && start;
        o_cmd.index   = (r_state == S_INDEX);
        o_cmd.read    = (r_state == S_READ);
        o_cmd.load    = (r_state == S_LOAD);
        o_cmd.step    = (r_state == S_TICK) && !i_stat.ticks_zero;
        o_cmd.finish  = (r_state == S_FINISH);
    end

    assign busy = r_busy;

endmodule

// ----- hw/rtl/smce_dp.sv -----
module smce_dp
    import smce_pkg::*;
#(
    parameter int COLUMNS = SMCE_COLUMNS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_dp_cmd                    i_cmd,
    output t_dp_stat                   o_stat,
    input  t_item                      i_item,
    input  logic                       i_cfg_we,
    input  logic [SMCE_CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [SMCE_CFG_DATA_W-1:0] i_cfg_data,
    output logic                       o_valid,
    output t_result                    o_result
);

    localparam int IDX_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

    // byte mod 3: base-4 digit sum taken twice, then two conditional subtracts
    function automatic logic [1:0] mod3(input logic [7:0] v);
        logic [3:0] s;
        logic [2:0] t;
        s = 4'(v[1:0]) + 4'(v[3:2]) + 4'(v[5:4]) + 4'(v[7:6]);
        t = 3'(s[1:0]) + 3'(s[3:2]);
        if (t >= 3'd3) t = t - 3'd3;
        if (t >= 3'd3) t = t - 3'd3;
        return t[1:0];
    endfunction

    logic [SMCE_HEIGHT_W-1:0] r_height;
    logic                     r_hires;
    logic signed [4:0]        r_prev;

    t_item                        r_item;
    logic [IDX_W-1:0]             r_col;
    logic signed [SMCE_OFF_W-1:0] r_mem [COLUMNS];
    logic signed [SMCE_OFF_W-1:0] r_mem_q;
    logic signed [SMCE_OFF_W-1:0] r_off;
    logic [SMCE_TICK_W-1:0]       r_ticks;
    logic                         r_moved;
    logic                         r_valid;
    t_result                      r_result;

    logic [IDX_W-1:0]             n_col;
    logic signed [SMCE_OFF_W-1:0] n_init;
    logic signed [SMCE_OFF_W-1:0] n_step;
    logic                         n_moved;
    t_result                      n_result;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_height <= SMCE_HEIGHT_RST;
            r_hires  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_HEIGHT: r_height <= i_cfg_data[SMCE_HEIGHT_W-1:0];
                CFG_HIRES:  r_hires  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // column wrap: reciprocal multiply, remainder in the following cycle
    if (COLUMNS < 256) begin : g_wrap
        localparam logic [16:0] RECIP = 17'((65536 + COLUMNS - 1) / COLUMNS);
        logic [24:0] w_prod;
        logic [7:0]  r_quot;
        logic [7:0]  w_rem;

        assign w_prod = 25'(i_item.column) * 25'(RECIP);
        assign w_rem  = r_item.column - 8'(16'(r_quot) * 16'(COLUMNS));
        assign n_col  = IDX_W'(w_rem);

        always_ff @(posedge i_clk) begin
            if (i_cmd.capture) begin
                r_quot <= w_prod[23:16];
            end
        end
    end else begin : g_nowrap
        assign n_col = IDX_W'(r_item.column);
    end

    // init value
    always_comb begin
        logic signed [5:0] sum;
        logic signed [4:0] v;
        sum = 6'(r_prev) + 6'(mod3(r_item.random_byte)) - 6'sd1;
        if (sum > 6'sd0) begin
            v = 5'sd0;
        end else if (sum == -6'sd16) begin
            v = -5'sd15;
        end else begin
            v = 5'(sum);
        end
        if (r_col == '0) begin
            v = 5'sd0 - $signed({1'b0, r_item.random_byte[3:0]});
        end
        n_init = SMCE_OFF_W'(v);
    end

    // one melt tick
    always_comb begin
        logic signed [12:0] off;
        logic signed [12:0] h;
        logic signed [12:0] dy;
        off     = 13'(r_off);
        h       = $signed({2'b0, r_height});
        dy      = '0;
        n_step  = r_off;
        n_moved = 1'b0;
        if (off < 13'sd0) begin
            n_step  = r_off + 12'sd1;
            n_moved = 1'b1;
        end else if (off < h) begin
            if (off < 13'sd16) begin
                dy = off + 13'sd1;
            end else begin
                dy = r_hires ? 13'sd16 : 13'sd8;
            end
            n_step  = (off + dy >= h) ? 12'(h) : 12'(off + dy);
            n_moved = 1'b1;
        end
    end

    // result of the finished item
    always_comb begin
        logic signed [12:0] off;
        logic signed [12:0] h;
        logic signed [12:0] row;
        logic signed [12:0] pos;
        off = 13'(r_off);
        h   = $signed({2'b0, r_height});
        row = $signed({3'b0, r_item.row});
        pos = (off > 13'sd0) ? off : 13'sd0;
        n_result             = '0;
        n_result.offset      = r_off;
        n_result.column_busy = (off < h);
        case (r_item.func)
            FUNC_TICK: n_result.column_busy = r_moved;
            FUNC_QUERY: begin
                if (row < off) begin
                    n_result.from_end   = 1'b1;
                    n_result.source_row = r_item.row;
                end else begin
                    n_result.source_row = SMCE_ROW_W'(row - pos);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_item;
        end
        if (i_cmd.index) begin
            r_col <= n_col;
        end
        if (i_cmd.read) begin
            r_mem_q <= r_mem[r_col];
        end
        if (i_cmd.load) begin
            r_off   <= (r_item.func == FUNC_INIT) ? n_init : r_mem_q;
            r_ticks <= r_item.tick_count;
            r_moved <= 1'b0;
        end
        if (i_cmd.step) begin
            r_off   <= n_step;
            r_ticks <= r_ticks - 1'b1;
            r_moved <= r_moved | n_moved;
        end
        if (i_cmd.finish) begin
            r_result <= n_result;
            if (r_item.func == FUNC_INIT || r_item.func == FUNC_TICK) begin
                r_mem[r_col] <= r_off;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= 5'sd0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.finish;
            if (i_cmd.load && r_item.func == FUNC_INIT) begin
                r_prev <= 5'(n_init);
            end
        end
    end

    assign o_stat.is_tick    = (r_item.func == FUNC_TICK);
    assign o_stat.ticks_zero = (r_ticks == '0);
    assign o_valid           = r_valid;
    assign o_result          = r_result;

endmodule

// ----- hw/rtl/screen_melt_column_engine.sv -----
// Column drop-offset engine for a melting screen wipe.
//
// Command channel: i_item is taken at a rising edge where start is high and
// busy is low. busy rises on the next cycle and stays high until the item is
// done; items offered while busy are ignored.
// Result channel: o_result is shown for exactly one cycle with o_valid high.
// There is no back-pressure; the receiver must take every beat.
// Config port: i_cfg_we writes i_cfg_data to register i_cfg_idx
// (0 = screen height, 1 = hires step) at that edge. Write only while idle.
//
// Timing: init and query items step through the index, RAM read, load and
// finish states, and the next item can be taken in the cycle that shows the
// result beat. A tick item also runs a tick loop between load and finish, one
// tick per cycle until tick_count ticks are done. The sequence is set by the
// column RAM read, which is registered, and the tick loop, which runs on a
// single adder/compare unit.
// Reset (synchronous, active low): height 200, hires off, chain seed 0,
// no beat pending. The column RAM is not cleared; columns must be seeded
// by an init item before they are ticked or queried.
module screen_melt_column_engine
    import smce_pkg::*;
#(
    parameter int COLUMNS = SMCE_COLUMNS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  t_item                      i_item,
    input  logic                       i_cfg_we,
    input  logic [SMCE_CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [SMCE_CFG_DATA_W-1:0] i_cfg_data,
    output logic                       o_valid,
    output t_result                    o_result
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // sequencer: index, RAM read, load, tick loop, write-back
    smce_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    // column RAM, config registers, init/tick/query arithmetic
    smce_dp #(
        .COLUMNS (COLUMNS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_item     (i_item),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_valid    (o_valid),
        .o_result   (o_result)
    );

endmodule

// ----- hw/rtl/smce_chk.sv -----
module smce_chk
    import smce_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    start,
    input logic    busy,
    input logic    o_valid,
    input t_result o_result
);

    // a result beat only appears once the engine is free again
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result beat while busy");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy && !o_valid)
        else $error("accepted item did not raise busy");

    a_single_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result beat longer than one cycle");

    a_end_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_result.from_end |->
            o_result.offset > $signed({2'b0, o_result.source_row}))
        else $error("end-screen row not above column offset");

endmodule

bind screen_melt_column_engine smce_chk u_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_valid  (o_valid),
    .o_result (o_result)
);
